// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the blur core. Define
// NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every rising clock edge outside reset
`define CFB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true outside reset
`define CFB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CFB_ASSERT(label, clk, rst_n, prop, msg)
`define CFB_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/cfb_pkg.sv -----
// ----------------------------------------------------------------------------
// cfb_pkg
// Types, constants and divide helpers shared by the cross blur modules.
// ----------------------------------------------------------------------------
package cfb_pkg;

	localparam int LANES      = 4;
	localparam int LANE_W     = 8;
	localparam int LANE_SUM_W = 11;   // five 8-bit terms
	localparam int MULT_W     = 11;
	localparam int PROD_W     = LANE_SUM_W + MULT_W;
	localparam int CNT_W      = 3;
	localparam int SHIFT_W    = 4;

	localparam logic [10:0] WIDTH_RESET  = 11'd1024;
	localparam logic [12:0] HEIGHT_RESET = 13'd1024;
	localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;

	// register map, index = paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// reciprocal constants, exact for sums up to 5*255
	localparam logic [MULT_W-1:0]  DIV3_MULT  = 11'd683;
	localparam logic [SHIFT_W-1:0] DIV3_SHIFT = 4'd11;
	localparam logic [MULT_W-1:0]  DIV5_MULT  = 11'd1639;
	localparam logic [SHIFT_W-1:0] DIV5_SHIFT = 4'd13;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_SUM,
		ST_MUL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;     // capture the accepted item
		logic rd;       // read both line stores
		logic rd_alt;   // 0: center column, 1: neighbor columns
		logic cap0;     // keep center reads
		logic sum;      // form lane sums and term count
		logic mul;      // reciprocal multiply
		logic commit;   // write stores, step counters, emit result
	} cmd_t;

	typedef struct packed {
		logic skip;     // drain item arrived too early
		logic emit;     // this item produces a result
		logic out_free; // output register can take a result
	} status_t;

	typedef struct packed {
		logic [10:0] frame_width;
		logic [12:0] frame_height;
		logic        clear;
	} cfg_t;

	function automatic logic [MULT_W-1:0] div_mult(input logic [CNT_W-1:0] cnt);
		logic [MULT_W-1:0] m;
		case (cnt)
			3'd3:    m = DIV3_MULT;
			3'd5:    m = DIV5_MULT;
			default: m = MULT_W'(1);
		endcase
		return m;
	endfunction

	function automatic logic [SHIFT_W-1:0] div_shift(input logic [CNT_W-1:0] cnt);
		logic [SHIFT_W-1:0] s;
		case (cnt)
			3'd2:    s = 4'd1;
			3'd3:    s = DIV3_SHIFT;
			3'd4:    s = 4'd2;
			3'd5:    s = DIV5_SHIFT;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/cfb_ctrl.sv -----
// ----------------------------------------------------------------------------
// cfb_ctrl
// Sequencer for one item: two store reads, sum, multiply, commit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_stall,
	input  cfb_pkg::status_t sts,
	output cfb_pkg::cmd_t    cmd
);
	import cfb_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pix_valid) state_d = ST_RD0;
			end
			ST_RD0: begin
				state_d = sts.skip ? ST_IDLE : ST_RD1;
			end
			ST_RD1:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (!sts.emit || sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		pix_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				pix_stall = 1'b0;
				cmd.load  = pix_valid;
			end
			ST_RD0: begin
				cmd.rd = !sts.skip;
			end
			ST_RD1: begin
				cmd.cap0   = 1'b1;
				cmd.rd     = 1'b1;
				cmd.rd_alt = 1'b1;
			end
			ST_SUM:  cmd.sum = 1'b1;
			ST_MUL:  cmd.mul = 1'b1;
			ST_EMIT: begin
				cmd.commit = !sts.emit || sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`CFB_ASSERT(a_load_idle, clk, arst_n, cmd.load |-> state_q == ST_IDLE, "load outside idle")
	`CFB_ASSERT(a_load_next, clk, arst_n, cmd.load |=> state_q == ST_RD0, "load not followed by read")
	`CFB_ASSERT_NEVER(a_no_overrun, clk, arst_n, cmd.commit && sts.emit && !sts.out_free,
		"result committed into a full output register")

endmodule

// ----- rtl/cfb_dp.sv -----
// ----------------------------------------------------------------------------
// cfb_dp
// Line stores, raster counters, lane sums, reciprocal divide, output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfb_dp #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfb_pkg::cfg_t    cfg,
	input  cfb_pkg::cmd_t    cmd,
	output cfb_pkg::status_t sts,
	input  logic             mode,
	input  logic [31:0]      pixel_in,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [31:0]      pixel_out,
	output logic             last_of_frame
);
	import cfb_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int CMPW = (WW > 11) ? WW : 11;

	logic [WW-1:0]   eff_w;
	logic [12:0]     eff_h;
	logic [CW-1:0]   col_q;
	logic [12:0]     row_q;
	logic [CW:0]     col_p1;
	logic            has_up, has_left, has_right, have_down, last_col;
	logic            mode_q;
	logic [31:0]     pix_q;
	logic [CW-1:0]   addr_m, addr_u;
	logic [31:0]     upper_mem [MAX_WIDTH];
	logic [31:0]     middle_mem [MAX_WIDTH];
	logic [31:0]     rd_mid_q, rd_up_q;
	logic [31:0]     center_q, up_q;
	logic [LANE_SUM_W-1:0] sum_d [LANES];
	logic [LANE_SUM_W-1:0] sum_q [LANES];
	logic [CNT_W-1:0]      cnt_d, cnt_q, cnt_mul_q;
	logic [PROD_W-1:0]     prod_q [LANES];
	logic [31:0]     quot;
	logic            res_valid_q, last_q;
	logic [31:0]     res_q;

	// clamp the frame size registers
	always_comb begin
		if (cfg.frame_width == '0) begin
			eff_w = WW'(1);
		end else if (CMPW'(cfg.frame_width) > CMPW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(cfg.frame_width);
		end
		if (cfg.frame_height == '0) begin
			eff_h = 13'd1;
		end else if (cfg.frame_height > HEIGHT_LIMIT) begin
			eff_h = HEIGHT_LIMIT;
		end else begin
			eff_h = cfg.frame_height;
		end
	end

	// neighbor presence
	assign col_p1    = (CW+1)'(col_q) + (CW+1)'(1);
	assign last_col  = col_p1 == (CW+1)'(eff_w);
	assign has_right = col_p1 < (CW+1)'(eff_w);
	assign has_left  = col_q != '0;
	assign has_up    = row_q > 13'd1;
	assign have_down = row_q < eff_h;

	assign sts.skip     = mode_q && have_down;
	assign sts.emit     = row_q != '0;
	assign sts.out_free = !res_valid_q || !res_stall;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			pix_q  <= pixel_in;
		end
	end

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg.clear) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.commit) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= (row_q == eff_h) ? 13'd0 : row_q + 13'd1;
			end else begin
				col_q <= col_p1[CW-1:0];
			end
		end
	end

	// read addresses: center column first, then right and left neighbors
	assign addr_m = cmd.rd_alt ? col_p1[CW-1:0] : col_q;
	assign addr_u = cmd.rd_alt ? (col_q - CW'(1)) : col_q;

	// upper line store
	always_ff @(posedge clk) begin
		if (cmd.commit) upper_mem[col_q] <= center_q;
		if (cmd.rd) rd_up_q <= upper_mem[addr_u];
	end

	// middle line store
	always_ff @(posedge clk) begin
		if (cmd.commit && have_down) middle_mem[col_q] <= pix_q;
		if (cmd.rd) rd_mid_q <= middle_mem[addr_m];
	end

	// hold the center reads while the neighbor reads run
	always_ff @(posedge clk) begin
		if (cmd.cap0) begin
			center_q <= rd_mid_q;
			up_q     <= rd_up_q;
		end
	end

	// lane sums over the terms inside the frame
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			sum_d[k] = LANE_SUM_W'(center_q[k*LANE_W +: LANE_W])
				+ (has_up    ? LANE_SUM_W'(up_q[k*LANE_W +: LANE_W])     : '0)
				+ (has_left  ? LANE_SUM_W'(rd_up_q[k*LANE_W +: LANE_W])  : '0)
				+ (has_right ? LANE_SUM_W'(rd_mid_q[k*LANE_W +: LANE_W]) : '0)
				+ (have_down ? LANE_SUM_W'(pix_q[k*LANE_W +: LANE_W])    : '0);
		end
		cnt_d = CNT_W'(1) + CNT_W'(has_up) + CNT_W'(has_left) + CNT_W'(has_right)
			+ CNT_W'(have_down);
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			sum_q <= sum_d;
			cnt_q <= cnt_d;
		end
	end

	// divide by term count: reciprocal multiply, then shift
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			for (int k = 0; k < LANES; k++) begin
				prod_q[k] <= PROD_W'(sum_q[k]) * PROD_W'(div_mult(cnt_q));
			end
			cnt_mul_q <= cnt_q;
		end
	end

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			quot[k*LANE_W +: LANE_W] = LANE_W'(prod_q[k] >> div_shift(cnt_mul_q));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit && sts.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && sts.emit) begin
			res_q  <= quot;
			last_q <= (row_q == eff_h) && last_col;
		end
	end

	assign res_valid     = res_valid_q;
	assign pixel_out     = res_q;
	assign last_of_frame = last_q;

	`CFB_ASSERT(a_col_range, clk, arst_n, (CW+1)'(col_q) < (CW+1)'(eff_w), "column beyond width")
	`CFB_ASSERT(a_row_range, clk, arst_n, row_q <= eff_h, "row beyond height")
	`CFB_ASSERT(a_cnt_range, clk, arst_n, cmd.mul |-> (cnt_q != '0 && cnt_q <= CNT_W'(5)),
		"term count out of range")

endmodule

// ----- rtl/cross_five_point_blur_core.sv -----
// ----------------------------------------------------------------------------
// cross_five_point_blur_core
// Streaming five-point cross blur over 32-bit four-channel raster pixels.
// ----------------------------------------------------------------------------
// Each pixel item passes through the item sequencer in order: the accepting
// state, two reads of the line stores (center column, then the left and right
// neighbors), a lane-sum state, a reciprocal multiply state and a commit state.
// A result is written to the output register at commit, and the next item is
// taken only once the sequencer is back in idle. A drain item that arrives
// while frame rows are still expected is dropped in the first read state,
// with no store read and no commit. The commit state holds while the output
// register is full and stalled. Results trail the input by one row; after the
// last row the source sends one drain item per column. Registers: frame_width
// at address 0, frame_height at address 4; writing either starts a new frame.
// ----------------------------------------------------------------------------
module cross_five_point_blur_core #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  logic        mode,
	input  logic [31:0] pixel_in,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [31:0] pixel_out,
	output logic        last_of_frame
);
	import cfb_pkg::*;

	logic        wr_en;
	logic [10:0] width_q;
	logic [12:0] height_q;
	cfg_t        cfg;
	cmd_t        cmd;
	status_t     sts;

	// configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[12:0];
				default:    width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = {21'd0, width_q};
			REG_HEIGHT: prdata = {19'd0, height_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.frame_width  = width_q;
	assign cfg.frame_height = height_q;
	assign cfg.clear        = wr_en;

	cfb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cfb_dp #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.pixel_in      (pixel_in),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.pixel_out     (pixel_out),
		.last_of_frame (last_of_frame)
	);

endmodule
